/* design/scmv_pkg.sv */
package scmv_pkg;

  localparam int unsigned VEC_DEPTH = 1024;
  localparam int unsigned AW        = $clog2(VEC_DEPTH);
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned PROD_W    = 2 * VAL_W - FRAC_W;
  localparam int unsigned T_W       = ACC_W + 2;

  typedef enum logic [1:0] {
    OP_LOAD_VEC = 2'd0,
    OP_LOAD_ACC = 2'd1,
    OP_APPLY    = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_MATRIX_CPLX = 2'd0,
    CFG_VECTOR_CPLX = 2'd1,
    CFG_TRANSPOSE   = 2'd2
  } cfg_idx_e;

  function automatic logic idx_in_range(logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(VEC_DEPTH);
  endfunction

  function automatic logic [AW-1:0] idx_to_addr(logic [IDX_W-1:0] idx);
    logic [31:0] ext;
    ext = 32'(idx);
    return ext[AW-1:0];
  endfunction

endpackage

/* design/scmv_ram.sv */
module scmv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/scmv_mul.sv */
module scmv_mul import scmv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     issue_i,
  input  logic signed [VAL_W-1:0]  a_i,
  input  logic signed [VAL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [2*VAL_W-1:0] full;
  logic signed [PROD_W-1:0]  prod_q;

  // Dropping the low fraction bits of the signed product rounds toward minus infinity.
  assign full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= full[2*VAL_W-1:FRAC_W];
    end
  end

  assign prod_o = prod_q;

endmodule

/* design/scmv_add.sv */
module scmv_add import scmv_pkg::*; (
  input  logic signed [T_W-1:0]   a_i,
  input  logic signed [T_W-1:0]   b_i,
  input  logic                    sub_i,
  output logic signed [T_W-1:0]   sum_o,
  output logic signed [ACC_W-1:0] sat_o
);

  logic signed [T_W:0] full;
  logic                fits;

  always_comb begin
    if (sub_i) begin
      full = {a_i[T_W-1], a_i} - {b_i[T_W-1], b_i};
    end else begin
      full = {a_i[T_W-1], a_i} + {b_i[T_W-1], b_i};
    end
  end

  assign sum_o = full[T_W-1:0];
  assign fits  = (&full[T_W:ACC_W-1]) | ~(|full[T_W:ACC_W-1]);

  always_comb begin
    priority if (fits) begin
      sat_o = full[ACC_W-1:0];
    end else if (full[T_W]) begin
      sat_o = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat_o = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

endmodule

/* design/sparse_complex_matvec.sv */
// Streaming sparse complex matrix-vector multiply-accumulate. Operations load an element of the
// vector x, load an element of the accumulator y, apply one nonzero entry A(row,col) (adding
// A*x[col] to y[row], or A*x[row] to y[col] in transpose mode), or read an element of y. Values
// are signed Q16.16 and accumulators signed Q32.16 with saturation. The block handles one
// transaction at a time: a load writes in the fetch state; a read fetches y and waits while the
// output is stalled; an apply runs fetch, MRR, MII, SUBR and ACCR, then MRI, ADDI and ACCI if
// the matrix or the vector is complex. One 32x32 multiplier and one adder are shared over the
// four partial products and the two accumulations. The x and y stores are single-port-write
// RAMs with no clearing after reset; elements must be loaded before they are used or read.
// Configuration is taken at any time but should change only while the block is idle.
module sparse_complex_matvec import scmv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic                    cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              operation_i,
  input  logic [IDX_W-1:0]        row_index_i,
  input  logic [IDX_W-1:0]        col_index_i,
  input  logic signed [VAL_W-1:0] value_real_i,
  input  logic signed [VAL_W-1:0] value_imag_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ACC_W-1:0] sum_real_o,
  output logic signed [ACC_W-1:0] sum_imag_o,
  output logic                    result_is_complex_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_FETCH = 10'b00_0000_0010,
    S_MRR   = 10'b00_0000_0100,
    S_MII   = 10'b00_0000_1000,
    S_SUBR  = 10'b00_0001_0000,
    S_ACCR  = 10'b00_0010_0000,
    S_MRI   = 10'b00_0100_0000,
    S_ADDI  = 10'b00_1000_0000,
    S_ACCI  = 10'b01_0000_0000,
    S_READ  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic mat_cplx_q, vec_cplx_q, trans_q;
  logic cplx;

  op_e                    op_q;
  logic [IDX_W-1:0]       row_q, col_q;
  logic signed [VAL_W-1:0] vr_q, vi_q;

  logic [IDX_W-1:0] x_idx, y_idx, vec_idx, acc_idx;
  logic             apply_ok, row_ok;

  logic                    vec_we, vec_re, acc_we, acc_re;
  logic [2*VAL_W-1:0]      vec_rdata;
  logic [2*ACC_W-1:0]      acc_rdata, acc_wdata;

  logic signed [VAL_W-1:0] mr, mi, xr, xi, mul_a, mul_b;
  logic                    mul_issue;
  logic signed [PROD_W-1:0] prod;
  logic signed [T_W-1:0]   prod_ext;

  logic signed [T_W-1:0]   add_a, add_b, add_sum;
  logic                    add_sub;
  logic signed [ACC_W-1:0] add_sat;
  logic signed [ACC_W-1:0] acc_re_old, acc_im_old;

  logic signed [T_W-1:0]   t_q, t_d;
  logic signed [ACC_W-1:0] res_re_q, res_re_d;

  logic                    out_valid_q, out_valid_d, out_load;
  logic signed [ACC_W-1:0] sum_real_q, sum_imag_q;
  logic                    out_cplx_q;

  logic in_accept;

  assign cfg_ready_o = 1'b1;
  assign cplx        = mat_cplx_q | vec_cplx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_cplx_q <= 1'b1;
      vec_cplx_q <= 1'b1;
      trans_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MATRIX_CPLX: mat_cplx_q <= cfg_data_i;
        CFG_VECTOR_CPLX: vec_cplx_q <= cfg_data_i;
        CFG_TRANSPOSE:   trans_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= op_e'(operation_i);
      row_q <= row_index_i;
      col_q <= col_index_i;
      vr_q  <= value_real_i;
      vi_q  <= value_imag_i;
    end
  end

  assign x_idx    = trans_q ? row_q : col_q;
  assign y_idx    = trans_q ? col_q : row_q;
  assign apply_ok = idx_in_range(x_idx) & idx_in_range(y_idx);
  assign row_ok   = idx_in_range(row_q);
  assign vec_idx  = (op_q == OP_APPLY) ? x_idx : row_q;
  assign acc_idx  = (op_q == OP_APPLY) ? y_idx : row_q;

  assign xr = vec_rdata[2*VAL_W-1:VAL_W];
  assign xi = vec_cplx_q ? vec_rdata[VAL_W-1:0] : '0;
  assign mr = vr_q;
  assign mi = mat_cplx_q ? vi_q : '0;

  assign acc_re_old = acc_rdata[2*ACC_W-1:ACC_W];
  assign acc_im_old = acc_rdata[ACC_W-1:0];
  assign prod_ext   = {{(T_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    state_d     = state_q;
    vec_we      = 1'b0;
    vec_re      = 1'b0;
    acc_we      = 1'b0;
    acc_re      = 1'b0;
    acc_wdata   = {res_re_q, add_sat};
    mul_issue   = 1'b0;
    mul_a       = mr;
    mul_b       = xr;
    add_a       = t_q;
    add_b       = prod_ext;
    add_sub     = 1'b0;
    t_d         = t_q;
    res_re_d    = res_re_q;
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        unique case (op_q)
          OP_LOAD_VEC: begin
            vec_we  = row_ok;
            state_d = S_IDLE;
          end
          OP_LOAD_ACC: begin
            acc_we    = row_ok;
            acc_wdata = {{(ACC_W-VAL_W){vr_q[VAL_W-1]}}, vr_q,
                         {(ACC_W-VAL_W){vi_q[VAL_W-1]}}, vi_q};
            state_d   = S_IDLE;
          end
          OP_APPLY: begin
            vec_re  = apply_ok;
            acc_re  = apply_ok;
            state_d = apply_ok ? S_MRR : S_IDLE;
          end
          OP_READ: begin
            acc_re  = row_ok;
            state_d = S_READ;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_MRR: begin
        mul_issue = 1'b1;
        state_d   = S_MII;
      end
      S_MII: begin
        mul_issue = 1'b1;
        mul_a     = mi;
        mul_b     = xi;
        t_d       = prod_ext;
        state_d   = S_SUBR;
      end
      S_SUBR: begin
        add_sub = 1'b1;
        t_d     = add_sum;
        state_d = S_ACCR;
      end
      S_ACCR: begin
        mul_issue = 1'b1;
        mul_a     = mi;
        mul_b     = xr;
        add_a     = {{(T_W-ACC_W){acc_re_old[ACC_W-1]}}, acc_re_old};
        add_b     = t_q;
        res_re_d  = add_sat;
        if (cplx) begin
          state_d = S_MRI;
        end else begin
          acc_we    = 1'b1;
          acc_wdata = {add_sat, acc_im_old};
          state_d   = S_IDLE;
        end
      end
      S_MRI: begin
        mul_issue = 1'b1;
        mul_a     = mr;
        mul_b     = xi;
        t_d       = prod_ext;
        state_d   = S_ADDI;
      end
      S_ADDI: begin
        t_d     = add_sum;
        state_d = S_ACCI;
      end
      S_ACCI: begin
        add_a     = {{(T_W-ACC_W){acc_im_old[ACC_W-1]}}, acc_im_old};
        add_b     = t_q;
        acc_we    = 1'b1;
        acc_wdata = {res_re_q, add_sat};
        state_d   = S_IDLE;
      end
      S_READ: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    res_re_q <= res_re_d;
  end

  scmv_ram #(
    .WIDTH (2 * VAL_W),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (idx_to_addr(vec_idx)),
    .wdata_i ({vr_q, vi_q}),
    .re_i    (vec_re),
    .raddr_i (idx_to_addr(vec_idx)),
    .rdata_o (vec_rdata)
  );

  scmv_ram #(
    .WIDTH (2 * ACC_W),
    .DEPTH (VEC_DEPTH)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (idx_to_addr(acc_idx)),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (idx_to_addr(acc_idx)),
    .rdata_o (acc_rdata)
  );

  scmv_mul u_mul (
    .clk_i   (clk_i),
    .issue_i (mul_issue),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod)
  );

  scmv_add u_add (
    .a_i   (add_a),
    .b_i   (add_b),
    .sub_i (add_sub),
    .sum_o (add_sum),
    .sat_o (add_sat)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sum_real_q <= row_ok ? acc_re_old : '0;
      sum_imag_q <= (row_ok && cplx) ? acc_im_old : '0;
      out_cplx_q <= cplx;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign sum_real_o          = sum_real_q;
  assign sum_imag_o          = sum_imag_q;
  assign result_is_complex_o = out_cplx_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("block not busy after an accepted transaction");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_READ))
    else $error("result appeared without a read");

  a_real_result_imag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_cplx_q) |-> (sum_imag_q == '0))
    else $error("real result carries an imaginary part");

  a_apply_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCI) |=> (state_q == S_IDLE))
    else $error("apply sequence did not end after the imaginary update");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import scmv_pkg::*;

  localparam int HOLD_CYCLES = 250;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEMS_PER_MODE = 250;
  localparam logic [IDX_W-1:0] TOP_IDX = '1;
  localparam longint ACC_TOP = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_BOTTOM = -(longint'(1) <<< (ACC_W - 1));

  typedef struct packed {
    logic [ACC_W-1:0] sum_re;
    logic [ACC_W-1:0] sum_im;
    logic             is_cplx;
  } acc_read_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_e cfg_index = CFG_MATRIX_CPLX;
  logic cfg_data = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  op_e operation = OP_LOAD_VEC;
  logic [IDX_W-1:0] row_index = '0;
  logic [IDX_W-1:0] col_index = '0;
  logic signed [VAL_W-1:0] value_real = '0;
  logic signed [VAL_W-1:0] value_imag = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ACC_W-1:0] sum_real;
  logic signed [ACC_W-1:0] sum_imag;
  logic result_is_complex;

  logic signed [VAL_W-1:0] x_re [VEC_DEPTH];
  logic signed [VAL_W-1:0] x_im [VEC_DEPTH];
  longint acc_re [VEC_DEPTH];
  longint acc_im [VEC_DEPTH];
  logic x_loaded [VEC_DEPTH];
  logic y_loaded [VEC_DEPTH];
  logic [IDX_W-1:0] x_list [$];
  logic [IDX_W-1:0] y_list [$];
  logic [IDX_W-1:0] last_y = '0;
  logic mat_cplx = 1'b1;
  logic vec_cplx = 1'b1;
  logic transp = 1'b0;
  acc_read_t expected_reads [$];

  int error_count = 0;
  logic calm = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  sparse_complex_matvec uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .operation_i         (operation),
    .row_index_i         (row_index),
    .col_index_i         (col_index),
    .value_real_i        (value_real),
    .value_imag_i        (value_imag),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .sum_real_o          (sum_real),
    .sum_imag_o          (sum_imag),
    .result_is_complex_o (result_is_complex)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(string what, logic [ACC_W-1:0] got, logic [ACC_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic longint q16_product(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
    return (longint'(a) * longint'(b)) >>> FRAC_W;
  endfunction

  function automatic longint clamp_acc(longint v);
    if (v > ACC_TOP) begin
      return ACC_TOP;
    end
    if (v < ACC_BOTTOM) begin
      return ACC_BOTTOM;
    end
    return v;
  endfunction

  task automatic predict_matvec(op_e op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                logic signed [VAL_W-1:0] re, logic signed [VAL_W-1:0] im);
    logic [IDX_W-1:0] xa;
    logic [IDX_W-1:0] ya;
    logic signed [VAL_W-1:0] mi;
    logic signed [VAL_W-1:0] xr;
    logic signed [VAL_W-1:0] xim;
    logic cplx;
    acc_read_t rd;
    cplx = mat_cplx | vec_cplx;
    case (op)
      OP_LOAD_VEC: begin
        x_re[row] = re;
        x_im[row] = im;
        if (x_loaded[row] !== 1'b1) begin
          x_loaded[row] = 1'b1;
          x_list.push_back(row);
        end
      end
      OP_LOAD_ACC: begin
        acc_re[row] = longint'(re);
        acc_im[row] = longint'(im);
        if (y_loaded[row] !== 1'b1) begin
          y_loaded[row] = 1'b1;
          y_list.push_back(row);
        end
      end
      OP_APPLY: begin
        xa = transp ? row : col;
        ya = transp ? col : row;
        mi = mat_cplx ? im : '0;
        xr = x_re[xa];
        xim = vec_cplx ? x_im[xa] : '0;
        acc_re[ya] = clamp_acc(acc_re[ya] + (q16_product(re, xr) - q16_product(mi, xim)));
        if (cplx) begin
          acc_im[ya] = clamp_acc(acc_im[ya] + (q16_product(mi, xr) + q16_product(re, xim)));
        end
      end
      OP_READ: begin
        rd.sum_re = ACC_W'(acc_re[row]);
        rd.sum_im = cplx ? ACC_W'(acc_im[row]) : '0;
        rd.is_cplx = cplx;
        expected_reads.push_back(rd);
      end
    endcase
  endtask

  always @(posedge clk_i) begin : check_reads
    acc_read_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_reads.size() == 0) begin
        report_mismatch("unexpected result", sum_real, '0);
      end else begin
        want = expected_reads.pop_front();
        if (sum_real !== want.sum_re) begin
          report_mismatch("sum_real", sum_real, want.sum_re);
        end
        if (sum_imag !== want.sum_im) begin
          report_mismatch("sum_imag", sum_imag, want.sum_im);
        end
        if (result_is_complex !== want.is_cplx) begin
          report_mismatch("result_is_complex", ACC_W'(result_is_complex), ACC_W'(want.is_cplx));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 36);
    end
  end

  task automatic send_item(op_e op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                           logic signed [VAL_W-1:0] re, logic signed [VAL_W-1:0] im);
    in_valid <= 1'b1;
    operation <= op;
    row_index <= row;
    col_index <= col;
    value_real <= re;
    value_imag <= im;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_matvec(op, row, col, re, im);
    if (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_idle();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_modes(logic m, logic v, logic t);
    cfg_idx_e regs [3] = '{CFG_MATRIX_CPLX, CFG_VECTOR_CPLX, CFG_TRANSPOSE};
    logic bits [3];
    bits = '{m, v, t};
    wait_for_idle();
    cfg_valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index <= regs[k];
      cfg_data <= bits[k];
      @(posedge clk_i);
      while (!cfg_ready) @(posedge clk_i);
      case (regs[k])
        CFG_MATRIX_CPLX: mat_cplx = bits[k];
        CFG_VECTOR_CPLX: vec_cplx = bits[k];
        default: transp = bits[k];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] random_value();
    logic [VAL_W-1:0] r;
    r = $urandom;
    case ($urandom_range(3))
      0: return r;
      1: return {{12{r[19]}}, r[19:0]};
      2: return {{16{r[15]}}, r[15:0]};
      default: begin
        case ($urandom_range(3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic send_random_item();
    int unsigned pick;
    op_e op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] xa;
    logic [IDX_W-1:0] ya;
    pick = $urandom_range(99);
    col = IDX_W'($urandom);
    if (pick < 30) begin
      op = (pick < 15) ? OP_LOAD_VEC : OP_LOAD_ACC;
      row = $urandom_range(1) ? IDX_W'($urandom) : IDX_W'($urandom_range(31));
    end else if (pick < 78) begin
      op = OP_APPLY;
      xa = x_list[$urandom_range(x_list.size() - 1)];
      ya = ($urandom_range(9) < 3) ? last_y : y_list[$urandom_range(y_list.size() - 1)];
      last_y = ya;
      row = transp ? xa : ya;
      col = transp ? ya : xa;
    end else begin
      op = OP_READ;
      row = ($urandom_range(3) == 0) ? last_y : y_list[$urandom_range(y_list.size() - 1)];
    end
    send_item(op, row, col, random_value(), random_value());
  endtask

  task automatic test_complex_basics();
    send_item(OP_LOAD_VEC, '0, TOP_IDX, 32'h0001_8000, 32'hfffe_0000);
    send_item(OP_LOAD_VEC, TOP_IDX, '0, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_LOAD_ACC, '0, TOP_IDX, 32'h8000_0000, 32'h7fff_ffff);
    send_item(OP_LOAD_ACC, TOP_IDX, '0, '0, '0);
    send_item(OP_APPLY, TOP_IDX, '0, 32'h0003_0000, 32'hffff_c000);
    send_item(OP_APPLY, '0, TOP_IDX, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_READ, '0, TOP_IDX, '1, '1);
    send_item(OP_READ, TOP_IDX, '0, '0, '0);
  endtask

  task automatic test_saturation();
    send_item(OP_LOAD_VEC, 10'd5, 10'd5, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_LOAD_ACC, 10'd5, 10'd5, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_APPLY, 10'd5, 10'd5, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(OP_APPLY, 10'd5, 10'd5, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_APPLY, 10'd5, 10'd5, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_READ, 10'd5, 10'd5, '0, '0);
  endtask

  task automatic test_real_modes();
    set_modes(1'b0, 1'b1, 1'b0);
    send_item(OP_LOAD_ACC, 10'd7, 10'd0, 32'h0002_0000, 32'h0003_0000);
    send_item(OP_APPLY, '0, '0, 32'hffff_8000, 32'h1234_5678);
    send_item(OP_READ, '0, '0, '0, '0);
    set_modes(1'b0, 1'b0, 1'b0);
    send_item(OP_LOAD_VEC, 10'd7, 10'd0, 32'h0000_8000, 32'h7fff_0000);
    send_item(OP_APPLY, 10'd7, 10'd7, 32'h0002_0000, 32'h0005_0000);
    send_item(OP_READ, 10'd7, 10'd0, '0, '0);
    set_modes(1'b1, 1'b0, 1'b0);
    send_item(OP_APPLY, 10'd7, 10'd7, 32'h0001_0000, 32'h0001_0000);
    set_modes(1'b1, 1'b1, 1'b0);
    send_item(OP_APPLY, 10'd7, 10'd7, 32'hfffe_8000, 32'h0001_0000);
    send_item(OP_READ, 10'd7, 10'd0, '0, '0);
  endtask

  task automatic test_transpose();
    set_modes(1'b1, 1'b1, 1'b1);
    send_item(OP_APPLY, '0, TOP_IDX, 32'hffff_ffff, 32'h0000_0001);
    send_item(OP_READ, TOP_IDX, '0, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [2:0] bits;
    for (int mode = 0; mode < 8; mode++) begin
      bits = 3'(mode);
      set_modes(bits[0], bits[1], bits[2]);
      calm <= (mode == 3);
      repeat (ITEMS_PER_MODE) send_random_item();
      calm <= 1'b0;
    end
  endtask

  task automatic test_output_holdoff();
    set_modes(1'b1, 1'b1, 1'b0);
    hold_req <= hold_req + 1;
    for (int k = 0; k < 18; k++) begin
      if (k % 3 == 0) begin
        send_item(OP_APPLY, y_list[$urandom_range(y_list.size() - 1)],
                  x_list[$urandom_range(x_list.size() - 1)], random_value(), random_value());
      end else begin
        send_item(OP_READ, y_list[$urandom_range(y_list.size() - 1)], IDX_W'($urandom),
                  random_value(), random_value());
      end
    end
    wait_for_idle();
    repeat (20) send_random_item();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_complex_basics();
    test_saturation();
    test_real_modes();
    test_transpose();
    test_random_traffic();
    test_output_holdoff();
    wait_for_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
